FILE: hdl/stam_pkg.sv
// Shared types, constants and the ratio-level function of the alarm monitor.
package stam_pkg;

  localparam int unsigned NumCond    = 5;
  localparam int unsigned InWidth    = 88;
  localparam int unsigned OutWidth   = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // condition slots
  localparam int unsigned SlotAngle  = 0;
  localparam int unsigned SlotGas    = 1;
  localparam int unsigned SlotVib    = 2;
  localparam int unsigned SlotSensor = 3;
  localparam int unsigned SlotSysErr = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegAngleThr = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGasThr   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegVibCount = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMaxErr   = 2'd3;

  localparam logic [10:0] AngleThrReset = 11'd300;
  localparam logic [15:0] GasThrReset   = 16'd1000;
  localparam logic [15:0] VibCountReset = 16'd5;
  localparam logic [15:0] MaxErrReset   = 16'd10;

  typedef enum logic [2:0] {
    LVL_NONE     = 3'd0,
    LVL_LOW      = 3'd1,
    LVL_MEDIUM   = 3'd2,
    LVL_HIGH     = 3'd3,
    LVL_CRITICAL = 3'd4
  } level_e;

  typedef enum logic [1:0] {
    SAFE_NORMAL    = 2'd0,
    SAFE_WARNING   = 2'd1,
    SAFE_ALARM     = 2'd2,
    SAFE_EMERGENCY = 2'd3
  } safety_e;

  typedef struct packed {
    logic [10:0] angle_thr;
    logic [15:0] gas_thr;
    logic [15:0] vib_count;
    logic [15:0] max_err;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] angle;
    logic               angle_valid;
    logic [15:0]        gas_ppm;
    logic               gas_valid;
    logic               vibration_seen;
    logic [15:0]        vibration_count;
    logic               vibration_valid;
    logic               sensors_ready;
    logic [15:0]        adc_errors;
    logic [15:0]        gpio_errors;
  } item_t;

  typedef struct packed {
    logic   [NumCond-1:0] active;
    level_e [NumCond-1:0] level;
  } cond_t;

  typedef struct packed {
    level_e      top_level;
    safety_e     safety_state;
    logic [2:0]  active_count;
    logic        health_ok;
  } result_t;

  // Level of v / t against 3, 2, 1.5 and 1, by cross-multiplication.
  function automatic level_e level_of(input logic [15:0] v, input logic [15:0] t);
    logic [17:0] vv;
    logic [17:0] v2;
    logic [17:0] t2;
    logic [17:0] t3;
    vv = {2'b00, v};
    v2 = {1'b0, v, 1'b0};
    t2 = {1'b0, t, 1'b0};
    t3 = t2 + {2'b00, t};
    if (vv >= t3)      level_of = LVL_CRITICAL;
    else if (vv >= t2) level_of = LVL_HIGH;
    else if (v2 >= t3) level_of = LVL_MEDIUM;
    else if (v >= t)   level_of = LVL_LOW;
    else               level_of = LVL_NONE;
  endfunction

endpackage

FILE: hdl/stam_cfg_regs.sv
// Configuration register bank of the alarm monitor.
module stam_cfg_regs import stam_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegAngleThr: cfg_d.angle_thr = cfg_data_i[10:0];
        RegGasThr:   cfg_d.gas_thr   = cfg_data_i;
        RegVibCount: cfg_d.vib_count = cfg_data_i;
        RegMaxErr:   cfg_d.max_err   = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_thr <= AngleThrReset;
      cfg_q.gas_thr   <= GasThrReset;
      cfg_q.vib_count <= VibCountReset;
      cfg_q.max_err   <= MaxErrReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/stam_cond_update.sv
// Next-state logic of the five alarm conditions and the health flag.
module stam_cond_update import stam_pkg::*; (
  input  cond_t cond_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output cond_t cond_o,
  output logic  healthy_o
);

  logic [11:0] angle_abs;
  logic        err_over;
  level_e      angle_lvl;
  level_e      gas_lvl;
  level_e      vib_lvl;

  // two's complement magnitude; the most negative code maps to itself
  assign angle_abs = item_i.angle[11] ? (~item_i.angle + 12'd1) : item_i.angle;

  assign err_over = (item_i.adc_errors > cfg_i.max_err) ||
                    (item_i.gpio_errors > cfg_i.max_err);

  assign angle_lvl = level_of({4'd0, angle_abs}, {5'd0, cfg_i.angle_thr});
  assign gas_lvl   = level_of(item_i.gas_ppm, cfg_i.gas_thr);
  assign vib_lvl   = level_of(item_i.vibration_count, cfg_i.vib_count);

  assign healthy_o = item_i.sensors_ready && !err_over;

  always_comb begin
    cond_o = cond_i;
    // latch failure conditions
    if (!item_i.sensors_ready) begin
      cond_o.active[SlotSensor] = 1'b1;
      cond_o.level[SlotSensor]  = LVL_HIGH;
    end
    if (err_over) begin
      cond_o.active[SlotSysErr] = 1'b1;
      cond_o.level[SlotSysErr]  = LVL_MEDIUM;
    end
    if (item_i.angle_valid) begin
      if (angle_abs > {1'b0, cfg_i.angle_thr}) begin
        cond_o.active[SlotAngle] = 1'b1;
        cond_o.level[SlotAngle]  = angle_lvl;
      end else begin
        cond_o.active[SlotAngle] = 1'b0;
      end
    end
    if (item_i.gas_valid) begin
      if (item_i.gas_ppm > cfg_i.gas_thr) begin
        cond_o.active[SlotGas] = 1'b1;
        cond_o.level[SlotGas]  = gas_lvl;
      end else begin
        cond_o.active[SlotGas] = 1'b0;
      end
    end
    if (item_i.vibration_valid) begin
      if (item_i.vibration_seen) begin
        cond_o.active[SlotVib] = 1'b1;
        cond_o.level[SlotVib]  = vib_lvl;
      end else begin
        cond_o.active[SlotVib] = 1'b0;
      end
    end
  end

endmodule

FILE: hdl/stam_summary.sv
// Highest active level, safety state and active count over the conditions.
module stam_summary import stam_pkg::*; (
  input  cond_t   cond_i,
  input  logic    healthy_i,
  output result_t result_o
);

  level_e     highest;
  logic [2:0] count;
  safety_e    state;

  always_comb begin
    highest = LVL_NONE;
    count   = 3'd0;
    for (int i = 0; i < NumCond; i++) begin
      if (cond_i.active[i]) begin
        count = count + 3'd1;
        if (cond_i.level[i] > highest) highest = cond_i.level[i];
      end
    end
  end

  always_comb begin
    case (highest)
      LVL_NONE:   state = SAFE_NORMAL;
      LVL_LOW:    state = SAFE_WARNING;
      LVL_MEDIUM: state = SAFE_ALARM;
      default:    state = SAFE_EMERGENCY;
    endcase
  end

  assign result_o.top_level    = highest;
  assign result_o.safety_state = state;
  assign result_o.active_count = count;
  assign result_o.health_ok    = healthy_i;

endmodule

FILE: hdl/sensor_threshold_alarm_monitor.sv
// Sensor threshold alarm monitor: stream ports, input and result registers.
//
// Usage: each word on the s_axis channel is one monitoring pass; it yields
// exactly one word on the m_axis channel with the highest active alarm
// level, the safety state, the number of active conditions and a health
// flag. Thresholds and the error limit are written over the cfg channel
// (index 0 angle, 1 gas, 2 vibration count, 3 error limit), which is always
// ready; write it only while no pass is in flight.
// m_axis_tvalid rises as the word enters the result register.
// Throughput: one word per cycle unless the receiver stalls; the condition
// update and summary sit in a single stage between the input register and
// the result register. Reset clears all five conditions, restores the
// default thresholds and empties both registers. When the receiver stalls,
// the result register holds its word and the input register still takes
// one more word; then s_axis_tready drops until the result is taken.
module sensor_threshold_alarm_monitor import stam_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // cfg channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // from bit 0: angle[11:0], angle_valid, gas_ppm[15:0], gas_valid,
  // vibration_seen, vibration_count[15:0], vibration_valid, sensors_ready,
  // adc_errors[15:0], gpio_errors[15:0], zero fill
  input  logic [InWidth-1:0]  s_axis_tdata,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // from bit 0: top_level[2:0], safety_state[1:0], active_count[2:0],
  // health_ok, zero fill
  output logic [OutWidth-1:0] m_axis_tdata
);

  cfg_t    cfg;
  item_t   item;
  cond_t   cond_q, cond_d;
  result_t result;
  logic    healthy;

  logic               in_vld_q, in_vld_d;
  logic [InWidth-1:0] in_data_q;
  logic               out_vld_q, out_vld_d;
  result_t            out_q;
  logic               advance;
  logic               in_take;

  stam_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // unpack the held word
  assign item.angle           = in_data_q[11:0];
  assign item.angle_valid     = in_data_q[12];
  assign item.gas_ppm         = in_data_q[28:13];
  assign item.gas_valid       = in_data_q[29];
  assign item.vibration_seen  = in_data_q[30];
  assign item.vibration_count = in_data_q[46:31];
  assign item.vibration_valid = in_data_q[47];
  assign item.sensors_ready   = in_data_q[48];
  assign item.adc_errors      = in_data_q[64:49];
  assign item.gpio_errors     = in_data_q[80:65];

  stam_cond_update u_cond (
    .cond_i    (cond_q),
    .item_i    (item),
    .cfg_i     (cfg),
    .cond_o    (cond_d),
    .healthy_o (healthy)
  );

  stam_summary u_sum (
    .cond_i    (cond_d),
    .healthy_i (healthy),
    .result_o  (result)
  );

  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take)      in_vld_d = 1'b1;
    else if (advance) in_vld_d = 1'b0;
    out_vld_d = advance ? in_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cond_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      // commit the condition update as the word moves to the result register
      if (advance && in_vld_q) cond_q <= cond_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take)              in_data_q <= s_axis_tdata;
    if (advance && in_vld_q)  out_q     <= result;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q.health_ok, out_q.active_count,
                          out_q.safety_state, out_q.top_level};

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.active_count <= 3'd5))
    else $error("active count above five");

  a_state_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_q.top_level == LVL_NONE) ==
                       (out_q.safety_state == SAFE_NORMAL)))
    else $error("safety state disagrees with highest level");

  a_unhealthy_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q.health_ok) |-> (out_q.active_count != 3'd0))
    else $error("unhealthy pass without an active condition");

  a_sensor_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cond_q.active[SlotSensor] |=> cond_q.active[SlotSensor])
    else $error("sensor failure condition cleared");

  a_syserr_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cond_q.active[SlotSysErr] |=> cond_q.active[SlotSysErr])
    else $error("system error condition cleared");
`endif

endmodule

FILE: tb/sensor_threshold_alarm_monitor_test.sv
// Self-checking bench for the alarm monitor: directed table, random passes, scoreboard.
module sensor_threshold_alarm_monitor_test;
  import stam_pkg::*;

  localparam int HalfPeriod = 5;
  localparam int CycleLimit = 200000;
  localparam int LateFirst  = 17;
  localparam int TableRows  = 27;
  localparam int PhaseWords = 230;

  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } table_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // from bit 0: angle, angle_valid, gas_ppm, gas_valid, vibration_seen,
  // vibration_count, vibration_valid, sensors_ready, adc_errors, gpio_errors
  logic [InWidth-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // from bit 0: top_level, safety_state, active_count, health_ok
  logic [OutWidth-1:0] m_axis_tdata;

  // predictor copy of thresholds and condition table
  int     angle_limit = int'(AngleThrReset);
  int     gas_limit   = int'(GasThrReset);
  int     vib_limit   = int'(VibCountReset);
  int     error_limit = int'(MaxErrReset);
  bit     cond_on  [NumCond];
  level_e cond_lvl [NumCond];

  result_t    expected_summaries[$];
  table_row_t pass_table[TableRows];
  item_t      offered_word;
  bit         offered_typed;
  result_t    offered_want;
  int         mismatch_count;
  int         result_count;
  int         burst_left;
  int         cycle_count;

  sensor_threshold_alarm_monitor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HalfPeriod clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic level_e ratio_level(int v, int t);
    if (v >= 3 * t) return LVL_CRITICAL;
    if (v >= 2 * t) return LVL_HIGH;
    if (2 * v >= 3 * t) return LVL_MEDIUM;
    if (v >= t) return LVL_LOW;
    return LVL_NONE;
  endfunction

  // Advance the condition table by one pass and summarize it.
  function automatic result_t predict_summary(item_t w);
    result_t r;
    int      mag;
    int      n;
    level_e  top;
    bit      ok;
    mag = int'(w.angle);
    if (mag < 0) mag = -mag;
    ok = 1'b1;
    if (!w.sensors_ready) begin
      ok = 1'b0;
      cond_on[SlotSensor] = 1'b1;
      cond_lvl[SlotSensor] = LVL_HIGH;
    end
    if (int'(w.adc_errors) > error_limit || int'(w.gpio_errors) > error_limit) begin
      ok = 1'b0;
      cond_on[SlotSysErr] = 1'b1;
      cond_lvl[SlotSysErr] = LVL_MEDIUM;
    end
    if (w.angle_valid) begin
      cond_on[SlotAngle] = mag > angle_limit;
      if (mag > angle_limit) cond_lvl[SlotAngle] = ratio_level(mag, angle_limit);
    end
    if (w.gas_valid) begin
      cond_on[SlotGas] = int'(w.gas_ppm) > gas_limit;
      if (int'(w.gas_ppm) > gas_limit)
        cond_lvl[SlotGas] = ratio_level(int'(w.gas_ppm), gas_limit);
    end
    if (w.vibration_valid) begin
      cond_on[SlotVib] = w.vibration_seen;
      if (w.vibration_seen) cond_lvl[SlotVib] = ratio_level(int'(w.vibration_count), vib_limit);
    end
    n = 0;
    top = LVL_NONE;
    for (int i = 0; i < NumCond; i++) begin
      if (cond_on[i]) begin
        n++;
        if (cond_lvl[i] > top) top = cond_lvl[i];
      end
    end
    r.top_level = top;
    case (top)
      LVL_NONE:   r.safety_state = SAFE_NORMAL;
      LVL_LOW:    r.safety_state = SAFE_WARNING;
      LVL_MEDIUM: r.safety_state = SAFE_ALARM;
      default:    r.safety_state = SAFE_EMERGENCY;
    endcase
    r.active_count = n[2:0];
    r.health_ok = ok;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("mismatch on result %0d: %s got %0d want %0d", result_count, what, got, want);
  endtask

  // Scoreboard: check results first, then predict the word taken at this edge.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.top_level = level_e'(m_axis_tdata[2:0]);
        got.safety_state = safety_e'(m_axis_tdata[4:3]);
        got.active_count = m_axis_tdata[7:5];
        got.health_ok = m_axis_tdata[8];
        if (expected_summaries.size() == 0) begin
          report_mismatch("word with nothing pending", int'(m_axis_tdata), 0);
        end else begin
          want = expected_summaries.pop_front();
          if (got.top_level != want.top_level)
            report_mismatch("top_level", got.top_level, want.top_level);
          if (got.safety_state != want.safety_state)
            report_mismatch("safety_state", got.safety_state, want.safety_state);
          if (got.active_count != want.active_count)
            report_mismatch("active_count", got.active_count, want.active_count);
          if (got.health_ok != want.health_ok)
            report_mismatch("health_ok", got.health_ok, want.health_ok);
        end
        result_count++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_summary(offered_word);
        expected_summaries.push_back(offered_typed ? offered_want : want);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegAngleThr: angle_limit = int'(cfg_data_i[10:0]);
          RegGasThr:   gas_limit = int'(cfg_data_i);
          RegVibCount: vib_limit = int'(cfg_data_i);
          RegMaxErr:   error_limit = int'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  // Receiver: changing stall pattern, plus a long hold-off now and then.
  initial begin
    int rx_cycle;
    int hold_left;
    int mode;
    rx_cycle = 0;
    hold_left = 0;
    mode = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle % 1024 == 300) hold_left = 48;
      if (rx_cycle % 32 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        case (mode)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = ($urandom_range(0, 1) != 0);
          2:       m_axis_tready = (rx_cycle % 4 == 0);
          default: m_axis_tready = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic item_t pass_word(int ang, bit av, int gas, bit gv, bit vs, int vc, bit vv,
                                      bit rdy, int adc, int gpio);
    item_t w;
    w.angle = ang[11:0];
    w.angle_valid = av;
    w.gas_ppm = gas[15:0];
    w.gas_valid = gv;
    w.vibration_seen = vs;
    w.vibration_count = vc[15:0];
    w.vibration_valid = vv;
    w.sensors_ready = rdy;
    w.adc_errors = adc[15:0];
    w.gpio_errors = gpio[15:0];
    return w;
  endfunction

  function automatic result_t summary(level_e h, safety_e s, int n, bit ok);
    result_t r;
    r.top_level = h;
    r.safety_state = s;
    r.active_count = n[2:0];
    r.health_ok = ok;
    return r;
  endfunction

  // Value near one of the ratio steps of t, or anywhere in range.
  function automatic int near_step(int t, int top);
    int v;
    case ($urandom_range(0, 5))
      0:       v = $urandom_range(0, top);
      1:       v = t;
      2:       v = (3 * t) / 2;
      3:       v = 2 * t;
      4:       v = 3 * t;
      default: v = $urandom_range(0, t);
    endcase
    v = v + $urandom_range(0, 2) - 1;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic item_t random_word(bit allow_latch);
    int mag;
    int adc;
    int gpio;
    mag = near_step(angle_limit, 1800);
    if ($urandom_range(0, 1)) mag = -mag;
    if (allow_latch && $urandom_range(0, 3) == 0) begin
      adc = $urandom_range(0, 65535);
      gpio = $urandom_range(0, 65535);
    end else begin
      adc = $urandom_range(0, error_limit);
      gpio = $urandom_range(0, error_limit);
    end
    return pass_word(mag, $urandom_range(0, 4) != 0,
                     near_step(gas_limit, 65535), $urandom_range(0, 4) != 0,
                     $urandom_range(0, 9) < 7, near_step(vib_limit, 65535),
                     $urandom_range(0, 4) != 0,
                     allow_latch ? ($urandom_range(0, 9) != 0) : 1'b1, adc, gpio);
  endfunction

  // Offer one word; when the current burst is used up, sometimes idle first.
  task automatic send_word(item_t w, bit typed, result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk_i);
    offered_word = w;
    offered_typed = typed;
    offered_want = want;
    s_axis_tdata = {7'd0, w.gpio_errors, w.adc_errors, w.sensors_ready, w.vibration_valid,
                    w.vibration_count, w.vibration_seen, w.gas_valid, w.gas_ppm,
                    w.angle_valid, w.angle};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and wait for the block to drain.
  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_summaries.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int data);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data[CfgDataW-1:0];
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_thresholds(int ang, int gas, int vib, int errs);
    drain();
    write_reg(RegAngleThr, ang);
    write_reg(RegGasThr, gas);
    write_reg(RegVibCount, vib);
    write_reg(RegMaxErr, errs);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    result_t none;
    none = summary(LVL_NONE, SAFE_NORMAL, 0, 1'b1);
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    offered_word = '0;
    offered_typed = 1'b0;
    offered_want = '0;
    mismatch_count = 0;
    result_count = 0;
    burst_left = 0;
    cycle_count = 0;
    for (int i = 0; i < NumCond; i++) begin
      cond_on[i] = 1'b0;
      cond_lvl[i] = LVL_NONE;
    end

    // early rows: reset thresholds, no latching condition
    pass_table[0]  = '{pass_word(0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1, none};
    pass_table[1]  = '{pass_word(1800, 1, 0, 0, 0, 0, 0, 1, 0, 0), 1,
                       summary(LVL_CRITICAL, SAFE_EMERGENCY, 1, 1)};
    pass_table[2]  = '{pass_word(-1800, 1, 0, 0, 0, 0, 0, 1, 0, 0), 1,
                       summary(LVL_CRITICAL, SAFE_EMERGENCY, 1, 1)};
    pass_table[3]  = '{pass_word(300, 1, 0, 0, 0, 0, 0, 1, 0, 0), 1, none};
    pass_table[4]  = '{pass_word(-301, 1, 0, 0, 0, 0, 0, 1, 0, 0), 1,
                       summary(LVL_LOW, SAFE_WARNING, 1, 1)};
    pass_table[5]  = '{pass_word(450, 1, 0, 0, 0, 0, 0, 1, 0, 0), 1,
                       summary(LVL_MEDIUM, SAFE_ALARM, 1, 1)};
    pass_table[6]  = '{pass_word(-600, 1, 0, 0, 0, 0, 0, 1, 0, 0), 1,
                       summary(LVL_HIGH, SAFE_EMERGENCY, 1, 1)};
    // invalid reading keeps the condition
    pass_table[7]  = '{pass_word(0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1,
                       summary(LVL_HIGH, SAFE_EMERGENCY, 1, 1)};
    pass_table[8]  = '{pass_word(0, 1, 0, 0, 0, 0, 0, 1, 0, 0), 1, none};
    pass_table[9]  = '{pass_word(0, 0, 65535, 1, 0, 0, 0, 1, 0, 0), 1,
                       summary(LVL_CRITICAL, SAFE_EMERGENCY, 1, 1)};
    pass_table[10] = '{pass_word(0, 0, 1000, 1, 0, 0, 0, 1, 0, 0), 1, none};
    pass_table[11] = '{pass_word(0, 0, 1499, 1, 0, 0, 0, 1, 0, 0), 0, none};
    // vibration below its count: active, but at level none
    pass_table[12] = '{pass_word(0, 0, 0, 1, 1, 0, 1, 1, 0, 0), 1,
                       summary(LVL_NONE, SAFE_NORMAL, 1, 1)};
    pass_table[13] = '{pass_word(0, 0, 0, 0, 1, 65535, 1, 1, 0, 0), 1,
                       summary(LVL_CRITICAL, SAFE_EMERGENCY, 1, 1)};
    pass_table[14] = '{pass_word(0, 0, 0, 0, 1, 4, 1, 1, 0, 0), 1,
                       summary(LVL_NONE, SAFE_NORMAL, 1, 1)};
    pass_table[15] = '{pass_word(0, 0, 0, 0, 0, 65535, 1, 1, 0, 0), 1, none};
    pass_table[16] = '{pass_word(0, 0, 0, 0, 1, 65535, 0, 1, 0, 0), 1, none};
    // late rows: sensor failure and system error latch until reset, so run them last
    pass_table[17] = '{pass_word(0, 1, 0, 1, 0, 0, 1, 1, 0, 0), 1, none};
    pass_table[18] = '{pass_word(0, 0, 0, 0, 0, 0, 0, 1, 10, 10), 1, none};
    pass_table[19] = '{pass_word(0, 0, 0, 0, 0, 0, 0, 1, 11, 0), 1,
                       summary(LVL_MEDIUM, SAFE_ALARM, 1, 0)};
    pass_table[20] = '{pass_word(0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1,
                       summary(LVL_MEDIUM, SAFE_ALARM, 1, 1)};
    pass_table[21] = '{pass_word(0, 0, 0, 0, 0, 0, 0, 1, 0, 65535), 1,
                       summary(LVL_MEDIUM, SAFE_ALARM, 1, 0)};
    pass_table[22] = '{pass_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                       summary(LVL_HIGH, SAFE_EMERGENCY, 2, 0)};
    pass_table[23] = '{pass_word(0, 0, 0, 0, 0, 0, 0, 1, 0, 0), 1,
                       summary(LVL_HIGH, SAFE_EMERGENCY, 2, 1)};
    pass_table[24] = '{pass_word(0, 0, 0, 0, 1, 0, 1, 1, 0, 0), 1,
                       summary(LVL_HIGH, SAFE_EMERGENCY, 3, 1)};
    pass_table[25] = '{pass_word(-1800, 1, 65535, 1, 1, 65535, 1, 0, 65535, 0), 1,
                       summary(LVL_CRITICAL, SAFE_EMERGENCY, 5, 0)};
    pass_table[26] = '{pass_word(0, 0, 1001, 1, 0, 0, 0, 1, 0, 0), 0, none};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < LateFirst; r++)
      send_word(pass_table[r].word, pass_table[r].typed, pass_table[r].want);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_thresholds(AngleThrReset, GasThrReset, VibCountReset, MaxErrReset);
        1:       set_thresholds(1, 1, 1, 0);
        2:       set_thresholds(1800, 65535, 65535, 65535);
        3:       set_thresholds($urandom_range(1, 1800), $urandom_range(1, 65535),
                                $urandom_range(1, 65535), $urandom_range(0, 65535));
        default: set_thresholds($urandom_range(1, 1800), $urandom_range(1, 3000),
                                $urandom_range(1, 300), $urandom_range(0, 100));
      endcase
      repeat (PhaseWords) send_word(random_word(1'b0), 1'b0, none);
    end

    set_thresholds(AngleThrReset, GasThrReset, VibCountReset, MaxErrReset);
    for (int r = LateFirst; r < TableRows; r++)
      send_word(pass_table[r].word, pass_table[r].typed, pass_table[r].want);
    repeat (40) send_word(random_word(1'b1), 1'b0, none);
    drain();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sensor_threshold_alarm_monitor.f
hdl/stam_pkg.sv
hdl/stam_cfg_regs.sv
hdl/stam_cond_update.sv
hdl/stam_summary.sv
hdl/sensor_threshold_alarm_monitor.sv
tb/sensor_threshold_alarm_monitor_test.sv
